// File: rtl/core/tsi_pkg.sv
// Shared types and constants of the train speed integrator core.
// No dependencies; every other file takes its names from here.
package tsi_pkg;

  localparam int TICK_W    = 16;
  localparam int LEVEL_W   = 9;
  localparam int CFG_W     = 24;
  localparam int TRACK_W   = 40;
  localparam int SPEED_W   = 25;
  localparam int MAG_W     = 24;
  localparam int POS_W     = 40;
  localparam int ACC_W     = 26;
  localparam int SUM_W     = 27;
  localparam int DSUM_W    = 42;
  localparam int MC_W      = 25;
  localparam int MPL_W     = 16;
  localparam int MUL_LEN_W = 5;

  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;

  localparam logic [MUL_LEN_W-1:0] LEVEL_MUL_LEN = 5'd9;
  localparam logic [MUL_LEN_W-1:0] TIME_MUL_LEN  = 5'd16;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 9'd256;
  localparam logic [MAG_W-1:0]   SNAP_LIMIT  = 24'd256;
  localparam logic [SPEED_W-1:0] REPORT_HYST = 25'd2560;

  typedef enum logic [2:0] {
    REG_MAX_FWD   = 3'd0,
    REG_MAX_BWD   = 3'd1,
    REG_DRIVE     = 3'd2,
    REG_BRAKE     = 3'd3,
    REG_EMERGENCY = 3'd4,
    REG_COAST     = 3'd5,
    REG_TRACK     = 3'd6
  } cfg_reg_e;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_DRV_GO   = 13'b0000000000010,
    S_DRV_WAIT = 13'b0000000000100,
    S_BRK_GO   = 13'b0000000001000,
    S_BRK_WAIT = 13'b0000000010000,
    S_ACC      = 13'b0000000100000,
    S_TA_GO    = 13'b0000001000000,
    S_TA_WAIT  = 13'b0000010000000,
    S_SPD      = 13'b0000100000000,
    S_TS_GO    = 13'b0001000000000,
    S_TS_WAIT  = 13'b0010000000000,
    S_DIST     = 13'b0100000000000,
    S_END      = 13'b1000000000000
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [MUL_LEN_W-1:0] len;
  } mul_req_t;

endpackage

// File: rtl/core/tsi_in_if.sv
// Input channel of the train speed integrator: one word per time tick.
// Depends on tsi_pkg for field widths.
interface tsi_in_if;
  logic                         valid;
  logic                         ready;
  logic [tsi_pkg::TICK_W-1:0]   tick_time;
  logic [tsi_pkg::LEVEL_W-1:0]  throttle;
  logic [tsi_pkg::LEVEL_W-1:0]  brake_level;
  logic                         reverse_request;
  logic                         emergency_request;

  modport source (output valid, tick_time, throttle, brake_level, reverse_request,
                  emergency_request, input ready);
  modport sink   (input valid, tick_time, throttle, brake_level, reverse_request,
                  emergency_request, output ready);
endinterface

// File: rtl/core/tsi_out_if.sv
// Result channel of the train speed integrator: one word per tick.
// Depends on tsi_pkg for field widths.
interface tsi_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tsi_pkg::SPEED_W-1:0] speed_now;
  logic [tsi_pkg::POS_W-1:0]          position;
  logic                               stopped_event;
  logic                               speed_change_event;
  logic                               direction_event;
  logic                               emergency_event;
  logic                               end_hit;

  modport source (output valid, speed_now, position, stopped_event, speed_change_event,
                  direction_event, emergency_event, end_hit, input ready);
  modport sink   (input valid, speed_now, position, stopped_event, speed_change_event,
                  direction_event, emergency_event, end_hit, output ready);
endinterface

// File: rtl/core/tsi_sermul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on tsi_pkg. Result is product >> len in prod_hi_o, next bit down in prod_lsb_o.
module tsi_sermul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tsi_pkg::mul_req_t         req_i,
  input  logic [tsi_pkg::MC_W-1:0]  mcand_i,
  input  logic [tsi_pkg::MPL_W-1:0] mplier_i,
  output logic                      done_o,
  output logic [tsi_pkg::MC_W-1:0]  prod_hi_o,
  output logic                      prod_lsb_o
);

  logic                          busy_q, busy_d;
  logic [tsi_pkg::MUL_LEN_W-1:0] cnt_q, cnt_d;
  logic [tsi_pkg::MC_W-1:0]      mc_q, mc_d;
  logic [tsi_pkg::MPL_W-1:0]     mpl_q, mpl_d;
  logic [tsi_pkg::MC_W-1:0]      acc_q, acc_d;
  logic [tsi_pkg::MPL_W-1:0]     lo_q, lo_d;
  logic [tsi_pkg::MC_W:0]        sum;

  assign sum = {1'b0, acc_q} + (mpl_q[0] ? {1'b0, mc_q} : '0);
  assign done_o     = busy_q && (cnt_q == tsi_pkg::MUL_LEN_W'(1));
  assign prod_hi_o  = acc_q;
  assign prod_lsb_o = lo_q[tsi_pkg::MPL_W-1];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    mc_d   = mc_q;
    mpl_d  = mpl_q;
    acc_d  = acc_q;
    lo_d   = lo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.len;
      mc_d   = mcand_i;
      mpl_d  = mplier_i;
      acc_d  = '0;
      lo_d   = '0;
    end else if (busy_q) begin
      acc_d = sum[tsi_pkg::MC_W:1];
      lo_d  = {sum[0], lo_q[tsi_pkg::MPL_W-1:1]};
      mpl_d = {1'b0, mpl_q[tsi_pkg::MPL_W-1:1]};
      cnt_d = cnt_q - tsi_pkg::MUL_LEN_W'(1);
      if (done_o) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mc_q  <= mc_d;
    mpl_q <= mpl_d;
    acc_q <= acc_d;
    lo_q  <= lo_d;
  end

endmodule

// File: rtl/core/train_speed_integrator_core.sv
// Top level of the train speed integrator: tick sequencer, speed and distance
// datapath, APB register file. Depends on tsi_pkg, tsi_in_if, tsi_out_if, tsi_sermul.
//
//   channel   kind          words                     handshake
//   in_if     sink          one tick per word         valid/ready
//   out_if    source        one result per tick       valid/ready
//   apb       slave, 64b    7 registers at 8*i        psel/penable, pready tied high
//
// A tick goes from acceptance to a valid result through four passes of the bit-serial
// multiplier (9 + 9 + 16 + 16 steps) and the accel, speed, distance and track-end steps.
// Reset clears the speed, distance, mode flags and registers; no clearing pass.
// A new tick is taken while the previous result waits; the last step holds until
// the output register is free.
module train_speed_integrator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tsi_in_if.sink                         in_if,
  tsi_out_if.source                      out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tsi_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tsi_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tsi_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  // registers
  logic [tsi_pkg::CFG_W-1:0]   max_fwd_q, max_bwd_q, drive_q, brake_q, emerg_q, coast_q;
  logic [tsi_pkg::TRACK_W-1:0] track_q;

  tsi_pkg::state_e state_q, state_d;

  // architectural state
  logic signed [tsi_pkg::SPEED_W-1:0] speed_q;
  logic [tsi_pkg::POS_W-1:0]          dist_q;
  logic                               rev_mode_q, emg_on_q, was_moving_q;
  logic [tsi_pkg::MAG_W-1:0]          last_rep_q;
  logic                               dir_ev_q, emg_ev_q;
  logic                               out_valid_q;

  // per-tick working values
  logic [tsi_pkg::TICK_W-1:0]         dt_q;
  logic [tsi_pkg::LEVEL_W-1:0]        thr_q, brk_q;
  logic [tsi_pkg::CFG_W-1:0]          a_q;
  logic                               acc_neg_q;
  logic [tsi_pkg::MC_W-1:0]           acc_mag_q;
  logic signed [tsi_pkg::SPEED_W-1:0] spd2_q;
  logic                               spd2_neg_q;
  logic [tsi_pkg::MAG_W-1:0]          spd2_mag_q;
  logic signed [tsi_pkg::DSUM_W-1:0]  dsum_q;

  // output word
  logic signed [tsi_pkg::SPEED_W-1:0] o_speed_q;
  logic [tsi_pkg::POS_W-1:0]          o_pos_q;
  logic                               o_stop_q, o_chg_q, o_dir_q, o_emg_q, o_end_q;

  logic accept, commit;
  logic [tsi_pkg::LEVEL_W-1:0] thr_sat, brk_sat;

  // multiplier
  tsi_pkg::mul_req_t          mul_req;
  logic [tsi_pkg::MC_W-1:0]   mul_mcand;
  logic [tsi_pkg::MPL_W-1:0]  mul_mplier;
  logic                       mul_done;
  logic [tsi_pkg::MC_W-1:0]   prod_hi;
  logic                       prod_lsb;
  logic [tsi_pkg::CFG_W-1:0]  level_prod;

  tsi_sermul u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mul_req),
    .mcand_i    (mul_mcand),
    .mplier_i   (mul_mplier),
    .done_o     (mul_done),
    .prod_hi_o  (prod_hi),
    .prod_lsb_o (prod_lsb)
  );

  assign level_prod = {prod_hi[tsi_pkg::CFG_W-2:0], prod_lsb};

  always_comb begin
    mul_req.start = 1'b0;
    mul_req.len   = tsi_pkg::TIME_MUL_LEN;
    mul_mcand     = '0;
    mul_mplier    = '0;
    unique case (state_q)
      tsi_pkg::S_DRV_GO: begin
        mul_req.start = 1'b1;
        mul_req.len   = tsi_pkg::LEVEL_MUL_LEN;
        mul_mcand     = {1'b0, drive_q};
        mul_mplier    = {{(tsi_pkg::MPL_W-tsi_pkg::LEVEL_W){1'b0}}, thr_q};
      end
      tsi_pkg::S_BRK_GO: begin
        mul_req.start = 1'b1;
        mul_req.len   = tsi_pkg::LEVEL_MUL_LEN;
        mul_mcand     = {1'b0, brake_q};
        mul_mplier    = {{(tsi_pkg::MPL_W-tsi_pkg::LEVEL_W){1'b0}}, brk_q};
      end
      tsi_pkg::S_TA_GO: begin
        mul_req.start = 1'b1;
        mul_mcand     = acc_mag_q;
        mul_mplier    = dt_q;
      end
      tsi_pkg::S_TS_GO: begin
        mul_req.start = 1'b1;
        mul_mcand     = {1'b0, spd2_mag_q};
        mul_mplier    = dt_q;
      end
      default: ;
    endcase
  end

  // handshakes
  assign in_if.ready = (state_q == tsi_pkg::S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign commit      = (state_q == tsi_pkg::S_END) && (!out_valid_q || out_if.ready);

  assign thr_sat = (in_if.throttle > tsi_pkg::FULL_LEVEL) ? tsi_pkg::FULL_LEVEL
                                                          : in_if.throttle;
  assign brk_sat = (in_if.brake_level > tsi_pkg::FULL_LEVEL) ? tsi_pkg::FULL_LEVEL
                                                             : in_if.brake_level;

  // acceleration
  logic                              spd_neg, spd_pos;
  logic signed [tsi_pkg::ACC_W-1:0]  a_s, b_s, c_s, e_s, acc_v, acc_abs;

  assign spd_neg = speed_q[tsi_pkg::SPEED_W-1];
  assign spd_pos = !spd_neg && (speed_q != '0);
  assign a_s = signed'({2'b00, a_q});
  assign b_s = signed'({2'b00, level_prod});
  assign c_s = signed'({2'b00, coast_q});
  assign e_s = signed'({2'b00, emerg_q});

  always_comb begin
    acc_v = '0;
    if (emg_on_q) begin
      if (spd_pos)      acc_v = -e_s;
      else if (spd_neg) acc_v = e_s;
    end else begin
      if (thr_q != '0) acc_v = rev_mode_q ? -a_s : a_s;
      if (spd_pos)      acc_v = acc_v - b_s;
      else if (spd_neg) acc_v = acc_v + b_s;
      if (thr_q == '0) begin
        if (spd_pos)      acc_v = acc_v - c_s;
        else if (spd_neg) acc_v = acc_v + c_s;
      end
    end
    acc_abs = acc_v[tsi_pkg::ACC_W-1] ? -acc_v : acc_v;
  end

  // speed update, clamp and snap
  logic signed [tsi_pkg::SUM_W-1:0] dv_s, spd_sum, lo_lim, hi_lim, spd_clamp, clamp_abs;
  logic [tsi_pkg::MAG_W-1:0]        clamp_mag;
  logic                             snap;

  always_comb begin
    dv_s    = signed'({2'b00, prod_hi});
    spd_sum = signed'({{2{speed_q[tsi_pkg::SPEED_W-1]}}, speed_q})
              + (acc_neg_q ? -dv_s : dv_s);
    lo_lim  = rev_mode_q ? -signed'({3'b000, max_bwd_q}) : '0;
    hi_lim  = rev_mode_q ? '0 : signed'({3'b000, max_fwd_q});
    if (spd_sum < lo_lim)      spd_clamp = lo_lim;
    else if (spd_sum > hi_lim) spd_clamp = hi_lim;
    else                       spd_clamp = spd_sum;
    clamp_abs = spd_clamp[tsi_pkg::SUM_W-1] ? -spd_clamp : spd_clamp;
    clamp_mag = clamp_abs[tsi_pkg::MAG_W-1:0];
    snap      = (thr_q == '0) && (clamp_mag < tsi_pkg::SNAP_LIMIT);
  end

  // distance update
  logic signed [tsi_pkg::DSUM_W-1:0] dd_s, dsum_v;

  assign dd_s   = signed'({{(tsi_pkg::DSUM_W-tsi_pkg::MC_W){1'b0}}, prod_hi});
  assign dsum_v = signed'({2'b00, dist_q}) + (spd2_neg_q ? -dd_s : dd_s);

  // track ends and events
  logic                               below, above, end_f, moving_f, stop_f, chg_f;
  logic [tsi_pkg::POS_W-1:0]          pos_f;
  logic signed [tsi_pkg::SPEED_W-1:0] spd_f;
  logic [tsi_pkg::MAG_W-1:0]          mag_f;
  logic signed [tsi_pkg::SPEED_W-1:0] diff;
  logic [tsi_pkg::SPEED_W-1:0]        diff_abs;

  always_comb begin
    below = dsum_q[tsi_pkg::DSUM_W-1];
    above = !below && (dsum_q[tsi_pkg::DSUM_W-2:0] > {1'b0, track_q});
    end_f = below || above;
    if (below)      pos_f = '0;
    else if (above) pos_f = track_q;
    else            pos_f = dsum_q[tsi_pkg::POS_W-1:0];
    spd_f    = end_f ? '0 : spd2_q;
    mag_f    = end_f ? '0 : spd2_mag_q;
    moving_f = (spd_f != '0);
    stop_f   = was_moving_q && !moving_f;
    diff     = signed'({1'b0, mag_f}) - signed'({1'b0, last_rep_q});
    diff_abs = diff[tsi_pkg::SPEED_W-1] ? unsigned'(-diff) : unsigned'(diff);
    chg_f    = diff_abs > tsi_pkg::REPORT_HYST;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsi_pkg::S_IDLE:     if (accept) state_d = tsi_pkg::S_DRV_GO;
      tsi_pkg::S_DRV_GO:   state_d = tsi_pkg::S_DRV_WAIT;
      tsi_pkg::S_DRV_WAIT: if (mul_done) state_d = tsi_pkg::S_BRK_GO;
      tsi_pkg::S_BRK_GO:   state_d = tsi_pkg::S_BRK_WAIT;
      tsi_pkg::S_BRK_WAIT: if (mul_done) state_d = tsi_pkg::S_ACC;
      tsi_pkg::S_ACC:      state_d = tsi_pkg::S_TA_GO;
      tsi_pkg::S_TA_GO:    state_d = tsi_pkg::S_TA_WAIT;
      tsi_pkg::S_TA_WAIT:  if (mul_done) state_d = tsi_pkg::S_SPD;
      tsi_pkg::S_SPD:      state_d = tsi_pkg::S_TS_GO;
      tsi_pkg::S_TS_GO:    state_d = tsi_pkg::S_TS_WAIT;
      tsi_pkg::S_TS_WAIT:  if (mul_done) state_d = tsi_pkg::S_DIST;
      tsi_pkg::S_DIST:     state_d = tsi_pkg::S_END;
      tsi_pkg::S_END:      if (commit) state_d = tsi_pkg::S_IDLE;
      default:             state_d = tsi_pkg::S_IDLE;
    endcase
  end

  // APB
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (tsi_pkg::cfg_reg_e'(paddr[5:3]))
      tsi_pkg::REG_MAX_FWD:   prdata = {40'd0, max_fwd_q};
      tsi_pkg::REG_MAX_BWD:   prdata = {40'd0, max_bwd_q};
      tsi_pkg::REG_DRIVE:     prdata = {40'd0, drive_q};
      tsi_pkg::REG_BRAKE:     prdata = {40'd0, brake_q};
      tsi_pkg::REG_EMERGENCY: prdata = {40'd0, emerg_q};
      tsi_pkg::REG_COAST:     prdata = {40'd0, coast_q};
      tsi_pkg::REG_TRACK:     prdata = {24'd0, track_q};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fwd_q    <= '0;
      max_bwd_q    <= '0;
      drive_q      <= '0;
      brake_q      <= '0;
      emerg_q      <= '0;
      coast_q      <= '0;
      track_q      <= '0;
      state_q      <= tsi_pkg::S_IDLE;
      speed_q      <= '0;
      dist_q       <= '0;
      rev_mode_q   <= 1'b0;
      emg_on_q     <= 1'b0;
      was_moving_q <= 1'b0;
      last_rep_q   <= '0;
      dir_ev_q     <= 1'b0;
      emg_ev_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        unique case (tsi_pkg::cfg_reg_e'(paddr[5:3]))
          tsi_pkg::REG_MAX_FWD:   max_fwd_q <= pwdata[tsi_pkg::CFG_W-1:0];
          tsi_pkg::REG_MAX_BWD:   max_bwd_q <= pwdata[tsi_pkg::CFG_W-1:0];
          tsi_pkg::REG_DRIVE:     drive_q   <= pwdata[tsi_pkg::CFG_W-1:0];
          tsi_pkg::REG_BRAKE:     brake_q   <= pwdata[tsi_pkg::CFG_W-1:0];
          tsi_pkg::REG_EMERGENCY: emerg_q   <= pwdata[tsi_pkg::CFG_W-1:0];
          tsi_pkg::REG_COAST:     coast_q   <= pwdata[tsi_pkg::CFG_W-1:0];
          tsi_pkg::REG_TRACK:     track_q   <= pwdata[tsi_pkg::TRACK_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        rev_mode_q <= in_if.reverse_request;
        dir_ev_q   <= (in_if.reverse_request != rev_mode_q);
        emg_on_q   <= in_if.emergency_request;
        emg_ev_q   <= in_if.emergency_request && !emg_on_q;
      end
      if (commit) begin
        speed_q      <= spd_f;
        dist_q       <= pos_f;
        was_moving_q <= moving_f;
        if (chg_f) last_rep_q <= mag_f;
        out_valid_q  <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dt_q  <= in_if.tick_time;
      thr_q <= thr_sat;
      brk_q <= brk_sat;
    end
    if (state_q == tsi_pkg::S_BRK_GO) a_q <= level_prod;
    if (state_q == tsi_pkg::S_ACC) begin
      acc_neg_q <= acc_v[tsi_pkg::ACC_W-1];
      acc_mag_q <= acc_abs[tsi_pkg::MC_W-1:0];
    end
    if (state_q == tsi_pkg::S_SPD) begin
      spd2_q     <= snap ? '0 : spd_clamp[tsi_pkg::SPEED_W-1:0];
      spd2_neg_q <= !snap && spd_clamp[tsi_pkg::SUM_W-1];
      spd2_mag_q <= snap ? '0 : clamp_mag;
    end
    if (state_q == tsi_pkg::S_DIST) dsum_q <= dsum_v;
    if (commit) begin
      o_speed_q <= spd_f;
      o_pos_q   <= pos_f;
      o_stop_q  <= stop_f;
      o_chg_q   <= chg_f;
      o_dir_q   <= dir_ev_q;
      o_emg_q   <= emg_ev_q;
      o_end_q   <= end_f;
    end
  end

  assign out_if.valid              = out_valid_q;
  assign out_if.speed_now          = o_speed_q;
  assign out_if.position           = o_pos_q;
  assign out_if.stopped_event      = o_stop_q;
  assign out_if.speed_change_event = o_chg_q;
  assign out_if.direction_event    = o_dir_q;
  assign out_if.emergency_event    = o_emg_q;
  assign out_if.end_hit            = o_end_q;

  // checks
  a_speed_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (out_if.speed_now == '0 ||
                out_if.speed_now[tsi_pkg::SPEED_W-1] == rev_mode_q))
    else $error("speed sign disagrees with direction mode");

  a_pos_on_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> ({1'b0, out_if.position} <= {1'b0, track_q}))
    else $error("position beyond track end");

  a_mul_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == tsi_pkg::S_DRV_WAIT || state_q == tsi_pkg::S_BRK_WAIT ||
                  state_q == tsi_pkg::S_TA_WAIT  || state_q == tsi_pkg::S_TS_WAIT))
    else $error("multiplier finished outside a wait step");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> ((!out_if.stopped_event && !out_if.end_hit) || out_if.speed_now == '0))
    else $error("stop or track end reported with nonzero speed");

endmodule
